// ===== rtl/mact_pkg.sv =====
// shared types and codes for the memory admission claim table
// no dependencies
`default_nettype none
package mact_pkg;

  localparam logic [2:0] OP_CLAIM   = 3'd0;
  localparam logic [2:0] OP_FORCE   = 3'd1;
  localparam logic [2:0] OP_RELEASE = 3'd2;
  localparam logic [2:0] OP_CHECK   = 3'd3;
  localparam logic [2:0] OP_PREEMPT = 3'd4;
  localparam logic [2:0] OP_NONE    = 3'd5;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_ACCEPTED = 2'd1;
  localparam logic [1:0] ST_REJECTED = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  localparam logic [1:0] REG_HOST    = 2'd0;
  localparam logic [1:0] REG_RESERVE = 2'd1;
  localparam logic [1:0] REG_POLICY  = 2'd2;

  localparam int EVICT_LIMIT = 32;

  typedef struct packed {
    logic [2:0]  op;
    logic [15:0] id;
    logic        model;
    logic [47:0] mem;
    logic [6:0]  cpus;
  } mact_req_t;

  typedef struct packed {
    logic [47:0] cap;
    logic        host_nz;
    logic        strict;
  } mact_cfg_t;

  typedef struct packed {
    logic [15:0] key;
    logic [47:0] mem;
    logic [6:0]  cpus;
    logic        kind;
  } mact_slot_t;

endpackage
`default_nettype wire

// ===== rtl/mact_front.sv =====
// front end: accepts transactions, classifies them and queues them
// depends on mact_pkg
`default_nettype none
module mact_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        req_type,
  input  wire logic [15:0]       claim_id,
  input  wire logic              is_model_kind,
  input  wire logic [47:0]       memory_bytes,
  input  wire logic signed [7:0] cpu_count,
  output logic                   q_valid,
  output mact_pkg::mact_req_t    q_data,
  input  wire logic              q_pop
);
  import mact_pkg::*;

  mact_req_t  entry [2];
  mact_req_t  cls;
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       push;

  always_comb begin
    cls.op    = (req_type > OP_PREEMPT) ? OP_NONE : req_type;
    cls.id    = claim_id;
    cls.model = is_model_kind;
    cls.mem   = memory_bytes;
    cls.cpus  = cpu_count[7] ? 7'd0 : cpu_count[6:0];
  end

  assign in_stall = (count == 2'd2);
  assign push     = in_valid && !in_stall;
  assign q_valid  = (count != 2'd0);
  assign q_data   = entry[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entry[wptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wptr <= !wptr;
      if (q_pop) rptr <= !rptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule
`default_nettype wire

// ===== rtl/mact_engine.sv =====
// back end: slot table, totals, sequencer for claims and preemption, result register
// depends on mact_pkg
`default_nettype none
module mact_engine #(
  parameter int MAX_CLAIMS = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire mact_pkg::mact_cfg_t  cfg,
  input  wire logic                 q_valid,
  input  wire mact_pkg::mact_req_t  q_data,
  output logic                      q_pop,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [1:0]                status,
  output logic [47:0]               available_bytes,
  output logic [52:0]               claimed_bytes,
  output logic [11:0]               claimed_cpus,
  output logic                      evicted_valid,
  output logic [15:0]               evicted_id,
  output logic                      last
);
  import mact_pkg::*;

  localparam int IW = (MAX_CLAIMS > 1) ? $clog2(MAX_CLAIMS) : 1;
  localparam logic [IW:0] N_C = (IW + 1)'(MAX_CLAIMS);
  localparam logic [IW-1:0] LAST_IDX = IW'(MAX_CLAIMS - 1);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_SCAN = 4'd1;
  localparam logic [3:0] S_PROJ = 4'd2;
  localparam logic [3:0] S_ACT  = 4'd3;
  localparam logic [3:0] S_PCHK = 4'd4;
  localparam logic [3:0] S_PCMP = 4'd5;
  localparam logic [3:0] S_PACT = 4'd6;
  localparam logic [3:0] S_FREE = 4'd7;
  localparam logic [3:0] S_EMIT = 4'd8;

  mact_slot_t slots [MAX_CLAIMS];
  mact_slot_t rd_q;
  logic [IW-1:0] rd_addr;
  logic          we;
  logic [IW-1:0] wa;
  mact_slot_t    wd;

  logic [MAX_CLAIMS-1:0] slot_valid;
  logic [3:0]    state;
  mact_req_t     req;
  logic [IW:0]   cnt;
  logic          p_v;
  logic [IW-1:0] p_idx;
  logic          found;
  logic [IW-1:0] at;
  logic [47:0]   ex_mem;
  logic [6:0]    ex_cpus;
  logic          free_found;
  logic [IW-1:0] free_at;
  logic          best_found;
  logic [IW-1:0] best_at;
  logic [47:0]   best_mem;
  logic [6:0]    best_cpus;
  logic [15:0]   best_key;
  logic [53:0]   proj;
  logic [1:0]    st;
  logic [5:0]    nev;
  logic [15:0]   ev_ids [EVICT_LIMIT];
  logic [52:0]   total_mem;
  logic [11:0]   total_cpu;
  logic [47:0]   avail;
  logic [4:0]    k;
  logic          over;
  logic          pv_valid;
  logic          emit_last;
  logic          load;
  logic [47:0]   free_now;

  assign rd_addr  = cnt[IW-1:0];
  assign pv_valid = slot_valid[p_idx];
  assign over     = cfg.host_nz && (proj > {6'd0, cfg.cap});
  assign free_now = ({5'd0, cfg.cap} > total_mem) ? (cfg.cap - total_mem[47:0]) : 48'd0;
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign emit_last = (nev == 6'd0) || ({1'b0, k} == nev - 6'd1);
  assign load     = (state == S_EMIT) && (!out_valid || !out_stall);

  always_comb begin
    we = 1'b0;
    wa = at;
    wd.key  = req.id;
    wd.mem  = req.mem;
    wd.cpus = req.cpus;
    wd.kind = req.model;
    if (state == S_ACT && (req.op == OP_CLAIM || req.op == OP_FORCE) &&
        !(req.op == OP_CLAIM && over && cfg.strict)) begin
      if (found) begin
        we = 1'b1;
      end else if (free_found) begin
        we = 1'b1;
        wa = free_at;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (we) slots[wa] <= wd;
    rd_q <= slots[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (state == S_PACT && best_found) ev_ids[nev[4:0]] <= best_key;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      slot_valid <= '0;
      total_mem  <= '0;
      total_cpu  <= '0;
      out_valid  <= 1'b0;
      p_v        <= 1'b0;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (q_valid) begin
            req <= q_data;
            st  <= ST_OK;
            nev <= 6'd0;
            found <= 1'b0;
            ex_mem <= 48'd0;
            ex_cpus <= 7'd0;
            free_found <= 1'b0;
            best_found <= 1'b0;
            cnt <= '0;
            p_v <= 1'b0;
            case (q_data.op)
              OP_PREEMPT: state <= S_PCHK;
              OP_CHECK:   state <= S_PROJ;
              OP_NONE:    state <= S_FREE;
              default:    state <= S_SCAN;
            endcase
          end
        end
        S_SCAN: begin
          if (cnt < N_C) begin
            p_v   <= 1'b1;
            p_idx <= cnt[IW-1:0];
            cnt   <= cnt + 1'b1;
          end else begin
            p_v <= 1'b0;
          end
          if (p_v) begin
            if (pv_valid && rd_q.key == req.id && !found) begin
              found   <= 1'b1;
              at      <= p_idx;
              ex_mem  <= rd_q.mem;
              ex_cpus <= rd_q.cpus;
            end
            if (!pv_valid && !free_found) begin
              free_found <= 1'b1;
              free_at    <= p_idx;
            end
            if (pv_valid && rd_q.kind && (!best_found || rd_q.mem > best_mem)) begin
              best_found <= 1'b1;
              best_at    <= p_idx;
              best_mem   <= rd_q.mem;
              best_cpus  <= rd_q.cpus;
              best_key   <= rd_q.key;
            end
            if (p_idx == LAST_IDX) begin
              p_v <= 1'b0;
              case (req.op)
                OP_PREEMPT: state <= S_PACT;
                OP_RELEASE: state <= S_ACT;
                default:    state <= S_PROJ;
              endcase
            end
          end
        end
        S_PROJ: begin
          proj  <= {1'b0, total_mem} - {6'd0, ex_mem} + {6'd0, req.mem};
          state <= S_ACT;
        end
        S_ACT: begin
          case (req.op)
            OP_CLAIM, OP_FORCE: begin
              if (req.op == OP_CLAIM && over) st <= cfg.strict ? ST_REJECTED : ST_ACCEPTED;
              if (!(req.op == OP_CLAIM && over && cfg.strict)) begin
                if (found || free_found) begin
                  slot_valid[wa] <= 1'b1;
                  total_mem <= proj[52:0];
                  total_cpu <= total_cpu - {5'd0, ex_cpus} + {5'd0, req.cpus};
                end else begin
                  st <= ST_FULL;
                end
              end
            end
            OP_RELEASE: begin
              if (found) begin
                slot_valid[at] <= 1'b0;
                total_mem <= total_mem - {5'd0, ex_mem};
                total_cpu <= total_cpu - {5'd0, ex_cpus};
              end
            end
            OP_CHECK: begin
              if (over) st <= cfg.strict ? ST_REJECTED : ST_ACCEPTED;
            end
            default: begin
            end
          endcase
          state <= S_FREE;
        end
        S_PCHK: begin
          avail <= free_now;
          state <= S_PCMP;
        end
        S_PCMP: begin
          k <= 5'd0;
          if (avail < req.mem && nev < 6'(EVICT_LIMIT)) begin
            best_found <= 1'b0;
            cnt   <= '0;
            p_v   <= 1'b0;
            state <= S_SCAN;
          end else begin
            state <= S_EMIT;
          end
        end
        S_PACT: begin
          k <= 5'd0;
          if (!best_found) begin
            state <= S_EMIT;
          end else begin
            nev <= nev + 6'd1;
            slot_valid[best_at] <= 1'b0;
            total_mem <= total_mem - {5'd0, best_mem};
            total_cpu <= total_cpu - {5'd0, best_cpus};
            state <= S_PCHK;
          end
        end
        S_FREE: begin
          avail <= free_now;
          k     <= 5'd0;
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (load) begin
            k <= k + 5'd1;
            if (emit_last) state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status          <= st;
      available_bytes <= avail;
      claimed_bytes   <= total_mem;
      claimed_cpus    <= total_cpu;
      evicted_valid   <= (nev != 6'd0);
      evicted_id      <= (nev != 6'd0) ? ev_ids[k] : 16'd0;
      last            <= emit_last;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/memory_admission_claim_table_unit.sv =====
// top level of the memory admission claim table: register port, front end, engine
// depends on mact_pkg, mact_front, mact_engine
//
// usage:
//   request channel (in_valid/in_stall) carries one request per transaction;
//   result channel (out_valid/out_stall) returns one result per request, or one
//   per evicted claim for a preempt (one if none is evicted), with last set on the final one
//   registers are written over the APB port at 0x00, 0x08, 0x10, by the user only while idle; not enforced
// timing:
//   a two-entry queue takes requests while the engine works; the engine runs
//   one request at a time
//   claim and release scan every slot of the table memory; admission check
//   and unknown types skip the scan
//   preempt scans the table once for each eviction that it tries
//   the slot scan runs through the single read port of the table
// reset:
//   synchronous; empties the table, clears totals, host 0, reserve 0, strict 1
// stall:
//   a stalled result holds in the output register; the queue keeps taking
//   requests until full, then raises in_stall
`default_nettype none
module memory_admission_claim_table_unit #(
  parameter int MAX_CLAIMS = 32
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [63:0]       pwdata,
  output logic [63:0]            prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire logic [2:0]        req_type,
  input  wire logic [15:0]       claim_id,
  input  wire logic              is_model_kind,
  input  wire logic [47:0]       memory_bytes,
  input  wire logic signed [7:0] cpu_count,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output logic [1:0]             status,
  output logic [47:0]            available_bytes,
  output logic [52:0]            claimed_bytes,
  output logic [11:0]            claimed_cpus,
  output logic                   evicted_valid,
  output logic [15:0]            evicted_id,
  output logic                   last
);
  import mact_pkg::*;

  logic [47:0] host_memory_bytes;
  logic [47:0] reserve_amount;
  logic        policy_strict;
  mact_cfg_t   cfg;
  logic        q_valid;
  mact_req_t   q_data;
  logic        q_pop;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      host_memory_bytes <= 48'd0;
      reserve_amount    <= 48'd0;
      policy_strict     <= 1'b1;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[4:3])
        REG_HOST:    host_memory_bytes <= pwdata[47:0];
        REG_RESERVE: reserve_amount    <= pwdata[47:0];
        REG_POLICY:  policy_strict     <= pwdata[0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (paddr[4:3])
      REG_HOST:    prdata = {16'd0, host_memory_bytes};
      REG_RESERVE: prdata = {16'd0, reserve_amount};
      REG_POLICY:  prdata = {63'd0, policy_strict};
      default:     prdata = 64'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    cfg.cap     <= (reserve_amount >= host_memory_bytes) ? 48'd0
                                                         : host_memory_bytes - reserve_amount;
    cfg.host_nz <= (host_memory_bytes != 48'd0);
    cfg.strict  <= policy_strict;
  end

  mact_front u_front (
    .clk, .rst, .in_valid, .in_stall, .req_type, .claim_id, .is_model_kind,
    .memory_bytes, .cpu_count, .q_valid, .q_data, .q_pop
  );

  mact_engine #(.MAX_CLAIMS(MAX_CLAIMS)) u_engine (
    .clk, .rst, .cfg, .q_valid, .q_data, .q_pop, .out_valid, .out_stall,
    .status, .available_bytes, .claimed_bytes, .claimed_cpus,
    .evicted_valid, .evicted_id, .last
  );

endmodule
`default_nettype wire

// ===== rtl/mact_checker.sv =====
// port-level checks for the memory admission claim table, bound to the top level
// depends on mact_pkg and memory_admission_claim_table_unit
`default_nettype none
module mact_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic [1:0]  status,
  input wire logic [52:0] claimed_bytes,
  input wire logic        evicted_valid,
  input wire logic [15:0] evicted_id,
  input wire logic        last
);
  import mact_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(claimed_bytes) && $stable(evicted_id))
    else $error("stalled result changed");

  a_single_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted_valid |-> last)
    else $error("non-eviction result without last");

  a_evict_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && evicted_valid |-> status == ST_OK)
    else $error("eviction with nonzero status");

  a_no_id: assert property (@(posedge clk) disable iff (rst)
    out_valid && !evicted_valid |-> evicted_id == 16'd0)
    else $error("evicted id without eviction");

  a_reset: assert property (@(posedge clk)
    !rst && $past(rst) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind memory_admission_claim_table_unit mact_checker u_mact_checker (
  .clk, .rst, .out_valid, .out_stall, .status, .claimed_bytes,
  .evicted_valid, .evicted_id, .last
);
`default_nettype wire
